### rtl/fsc_pkg.sv
// Shared types and constants for the frustum sphere cull test.
// No dependencies; used by fsc_plane, frustum_sphere_cull_test and the testbench.
package fsc_pkg;
   localparam int NUM_PLANES_DEF = 6;
   localparam int NRM_W = 18;
   localparam int OFS_W = 40;
   localparam int CRD_W = 24;
   localparam int SUM_W = CRD_W + 1;
   localparam int PRD_W = NRM_W + SUM_W;
   localparam int DST_W = 46;
   localparam int MAG_W = 45;
   localparam int LO_W = 23;
   localparam int HI_W = MAG_W - LO_W;
   localparam int SQS_W = 50;
   localparam int SQD_W = 2 * MAG_W;
   localparam int FRAC2_W = 32;
   localparam int REQ_DATA_W = 248;
   localparam int RSP_DATA_W = 8;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   typedef struct packed {
      logic en;
      logic wr;
   } ctl_type;
endpackage

### rtl/fsc_plane.sv
// One stored plane and its pipelined sphere-behind-plane test.
// Depends on fsc_pkg.
module fsc_plane (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fsc_pkg::ctl_type                         ctl,
   input  logic signed [fsc_pkg::NRM_W-1:0]         wr_nx,
   input  logic signed [fsc_pkg::NRM_W-1:0]         wr_ny,
   input  logic signed [fsc_pkg::NRM_W-1:0]         wr_nz,
   input  logic signed [fsc_pkg::OFS_W-1:0]         wr_ofs,
   input  logic signed [fsc_pkg::SUM_W-1:0]         sx,
   input  logic signed [fsc_pkg::SUM_W-1:0]         sy,
   input  logic signed [fsc_pkg::SUM_W-1:0]         sz,
   input  logic        [fsc_pkg::SQS_W-1:0]         s6,
   output logic                                     cull
);
   logic signed [fsc_pkg::NRM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [fsc_pkg::OFS_W-1:0] ofs_ff;
   logic signed [fsc_pkg::PRD_W-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [fsc_pkg::OFS_W:0]   w2_ff, w2_in;
   logic signed [fsc_pkg::DST_W-1:0] d_ff, d_in;
   logic        [fsc_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic                             neg4_ff, neg5_ff, neg6_ff, cull_ff, cull_in;
   logic        [2*fsc_pkg::HI_W-1:0]            hh_ff, hh_in;
   logic        [fsc_pkg::HI_W+fsc_pkg::LO_W-1:0] hl_ff, hl_in;
   logic        [2*fsc_pkg::LO_W-1:0]            ll_ff, ll_in;
   logic        [fsc_pkg::SQD_W-1:0]             sq_ff, sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff <= '0;
         ny_ff <= '0;
         nz_ff <= '0;
         ofs_ff <= '0;
      end else if (ctl.wr) begin
         nx_ff <= wr_nx;
         ny_ff <= wr_ny;
         nz_ff <= wr_nz;
         ofs_ff <= wr_ofs;
      end
   end

   always_comb begin
      px_in = fsc_pkg::PRD_W'(nx_ff) * fsc_pkg::PRD_W'(sx);
      py_in = fsc_pkg::PRD_W'(ny_ff) * fsc_pkg::PRD_W'(sy);
      pz_in = fsc_pkg::PRD_W'(nz_ff) * fsc_pkg::PRD_W'(sz);
      w2_in = $signed({ofs_ff, 1'b0});
      d_in = fsc_pkg::DST_W'(px_ff) + fsc_pkg::DST_W'(py_ff) + fsc_pkg::DST_W'(pz_ff)
           + fsc_pkg::DST_W'(w2_ff);
      mag_in = d_ff[fsc_pkg::DST_W-1] ? fsc_pkg::MAG_W'(-d_ff) : fsc_pkg::MAG_W'(d_ff);
      hh_in = mag_ff[fsc_pkg::MAG_W-1:fsc_pkg::LO_W] * mag_ff[fsc_pkg::MAG_W-1:fsc_pkg::LO_W];
      hl_in = mag_ff[fsc_pkg::MAG_W-1:fsc_pkg::LO_W] * mag_ff[fsc_pkg::LO_W-1:0];
      ll_in = mag_ff[fsc_pkg::LO_W-1:0] * mag_ff[fsc_pkg::LO_W-1:0];
      sq_in = (fsc_pkg::SQD_W'(hh_ff) << (2 * fsc_pkg::LO_W))
            + (fsc_pkg::SQD_W'(hl_ff) << (fsc_pkg::LO_W + 1))
            + fsc_pkg::SQD_W'(ll_ff);
      cull_in = neg6_ff && (sq_ff > fsc_pkg::SQD_W'({s6, {fsc_pkg::FRAC2_W{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         w2_ff <= w2_in;
         d_ff <= d_in;
         mag_ff <= mag_in;
         neg4_ff <= d_ff[fsc_pkg::DST_W-1];
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         neg5_ff <= neg4_ff;
         sq_ff <= sq_in;
         neg6_ff <= neg5_ff;
         cull_ff <= cull_in;
      end
   end

   assign cull = cull_ff;
endmodule

### rtl/frustum_sphere_cull_test.sv
// Frustum bounding-sphere cull test, top level.
// Throughput: one transaction per cycle while rsp_tready is high or no response is
// held; loads give no result. A load registers its fields in the first stage and
// writes the plane from there, in order with tests.
// Synchronous reset clears all planes to zero and empties the pipeline.
// Depends on fsc_pkg and fsc_plane.
module frustum_sphere_cull_test #(
   parameter int NUM_PLANES = fsc_pkg::NUM_PLANES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // plane_index, normal_x, normal_y, normal_z, plane_offset, box_x_min, box_x_max,
   // box_y_min, box_y_max, box_z_min, box_z_max, zero fill.
   input  logic [fsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command.
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // in_view, zero fill.
   output logic [fsc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   fsc_pkg::ctl_type ctl [NUM_PLANES];
   logic en;
   logic v1_ff, cmd1_ff;
   logic [2:0] idx1_ff;
   logic signed [fsc_pkg::NRM_W-1:0] nx1_ff, ny1_ff, nz1_ff;
   logic signed [fsc_pkg::OFS_W-1:0] ofs1_ff;
   logic signed [fsc_pkg::SUM_W-1:0] sx1_ff, sy1_ff, sz1_ff, ex1_ff, ey1_ff, ez1_ff;
   logic signed [fsc_pkg::CRD_W-1:0] x0, x1, y0, y1, z0, z1;
   logic signed [fsc_pkg::SQS_W-1:0] qx_ff, qy_ff, qz_ff;
   logic [fsc_pkg::SQS_W-1:0] s3_ff, s4_ff, s5_ff, s6_ff;
   logic [7:2] tv_ff;
   logic [NUM_PLANES-1:0] culls;
   logic rsp_tvalid_ff, rsp_tvalid_in, in_view_ff;

   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign x0 = req_tdata[120:97];
   assign x1 = req_tdata[144:121];
   assign y0 = req_tdata[168:145];
   assign y1 = req_tdata[192:169];
   assign z0 = req_tdata[216:193];
   assign z1 = req_tdata[240:217];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         tv_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (en) begin
            v1_ff <= req_tvalid;
            tv_ff <= {tv_ff[6:2], v1_ff && (cmd1_ff == fsc_pkg::CMD_TEST)};
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid_in = en ? tv_ff[7] : rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff <= req_tuser;
         idx1_ff <= req_tdata[2:0];
         nx1_ff <= req_tdata[20:3];
         ny1_ff <= req_tdata[38:21];
         nz1_ff <= req_tdata[56:39];
         ofs1_ff <= req_tdata[96:57];
         sx1_ff <= fsc_pkg::SUM_W'(x0) + fsc_pkg::SUM_W'(x1);
         sy1_ff <= fsc_pkg::SUM_W'(y0) + fsc_pkg::SUM_W'(y1);
         sz1_ff <= fsc_pkg::SUM_W'(z0) + fsc_pkg::SUM_W'(z1);
         ex1_ff <= fsc_pkg::SUM_W'(x1) - fsc_pkg::SUM_W'(x0);
         ey1_ff <= fsc_pkg::SUM_W'(y1) - fsc_pkg::SUM_W'(y0);
         ez1_ff <= fsc_pkg::SUM_W'(z1) - fsc_pkg::SUM_W'(z0);
         qx_ff <= fsc_pkg::SQS_W'(ex1_ff) * fsc_pkg::SQS_W'(ex1_ff);
         qy_ff <= fsc_pkg::SQS_W'(ey1_ff) * fsc_pkg::SQS_W'(ey1_ff);
         qz_ff <= fsc_pkg::SQS_W'(ez1_ff) * fsc_pkg::SQS_W'(ez1_ff);
         s3_ff <= unsigned'(qx_ff) + unsigned'(qy_ff) + unsigned'(qz_ff);
         s4_ff <= s3_ff;
         s5_ff <= s4_ff;
         s6_ff <= s5_ff;
         in_view_ff <= ~|culls;
      end
   end

   for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
      assign ctl[i].en = en;
      assign ctl[i].wr = en && v1_ff && (cmd1_ff == fsc_pkg::CMD_LOAD) && (idx1_ff == 3'(i));
      fsc_plane u_plane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[i]),
         .wr_nx  (nx1_ff),
         .wr_ny  (ny1_ff),
         .wr_nz  (nz1_ff),
         .wr_ofs (ofs1_ff),
         .sx     (sx1_ff),
         .sy     (sy1_ff),
         .sz     (sz1_ff),
         .s6     (s6_ff),
         .cull   (culls[i])
      );
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {{(fsc_pkg::RSP_DATA_W-1){1'b0}}, in_view_ff};

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(tv_ff)) else $error("Pipeline valid bits moved during a stall.");
   a_load_bubble: assert property (@(posedge clock) disable iff (reset)
      (en && v1_ff && cmd1_ff == fsc_pkg::CMD_LOAD) |=> !tv_ff[2])
      else $error("A load transaction produced a result slot.");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(tv_ff[7])) else $error("Result without a test transaction.");
`endif
endmodule

### tb/sv/frustum_sphere_cull_checker.sv
`timescale 1ns / 100ps
// Checker for the frustum sphere cull test: watches both stream channels,
// keeps its own copy of the planes and predicts in_view. Depends on fsc_pkg.
module frustum_sphere_cull_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [fsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [fsc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              tests_seen,
   output int                              culled_seen
);
   logic signed [fsc_pkg::NRM_W-1:0] nrm_x [6];
   logic signed [fsc_pkg::NRM_W-1:0] nrm_y [6];
   logic signed [fsc_pkg::NRM_W-1:0] nrm_z [6];
   logic signed [fsc_pkg::OFS_W-1:0] ofs [6];
   bit expected_in_view [$];

   function automatic bit predict_in_view(logic [fsc_pkg::REQ_DATA_W-1:0] d);
      logic signed [fsc_pkg::CRD_W-1:0] b [6];
      logic signed [63:0] sx, sy, sz, ex, ey, ez, dd;
      logic [127:0] sq, dsq;
      bit vis;
      vis = 1;
      for (int i = 0; i < 6; i++) b[i] = d[97 + i*fsc_pkg::CRD_W +: fsc_pkg::CRD_W];
      sx = 64'(b[0]) + 64'(b[1]); ex = 64'(b[1]) - 64'(b[0]);
      sy = 64'(b[2]) + 64'(b[3]); ey = 64'(b[3]) - 64'(b[2]);
      sz = 64'(b[4]) + 64'(b[5]); ez = 64'(b[5]) - 64'(b[4]);
      sq = 128'(ex*ex) + 128'(ey*ey) + 128'(ez*ez);
      for (int p = 0; p < 6; p++) begin
         dd = 64'(nrm_x[p])*sx + 64'(nrm_y[p])*sy + 64'(nrm_z[p])*sz + 2*64'(ofs[p]);
         if (dd < 0) begin
            dsq = 128'(-dd) * 128'(-dd);
            if (dsq > (sq << 32)) vis = 0;
         end
      end
      return vis;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < 6; p++) begin
            nrm_x[p] <= '0; nrm_y[p] <= '0; nrm_z[p] <= '0; ofs[p] <= '0;
         end
         expected_in_view.delete();
         fail_count <= 0; tests_seen <= 0; culled_seen <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_in_view.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               bit e;
               e = expected_in_view.pop_front();
               if (rsp_tdata !== {7'b0, e}) begin
                  $display("%0t: in_view mismatch, expected %h, actual %h",
                           $time, {7'b0, e}, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == fsc_pkg::CMD_TEST) begin
               bit v;
               v = predict_in_view(req_tdata);
               expected_in_view.push_back(v);
               tests_seen <= tests_seen + 1;
               if (!v) culled_seen <= culled_seen + 1;
            end else if (req_tdata[2:0] < 6) begin
               nrm_x[req_tdata[2:0]] <= req_tdata[3 +: fsc_pkg::NRM_W];
               nrm_y[req_tdata[2:0]] <= req_tdata[21 +: fsc_pkg::NRM_W];
               nrm_z[req_tdata[2:0]] <= req_tdata[39 +: fsc_pkg::NRM_W];
               ofs[req_tdata[2:0]] <= req_tdata[57 +: fsc_pkg::OFS_W];
            end
         end
         pending_count <= expected_in_view.size();
      end
   end
endmodule

### tb/sv/frustum_sphere_cull_test_tb.sv
`timescale 1ns / 100ps
// Top of the frustum sphere cull testbench: clock, reset, stimulus, verdict.
// Depends on fsc_pkg, frustum_sphere_cull_test and frustum_sphere_cull_checker.
module frustum_sphere_cull_test_tb;
   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   // plane_index, normal_x, normal_y, normal_z, plane_offset, box bounds, zero fill.
   logic [fsc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // command.
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   // in_view, zero fill.
   logic [fsc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int fail_count, pending_count, tests_seen, culled_seen;
   int idle_left = 0;
   bit quiet = 0;
   bit hold_off = 0;

   frustum_sphere_cull_test u_top (.*);
   frustum_sphere_cull_checker u_chk (.*);

   initial forever #2 clock = ~clock;

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_tready <= 0;
         idle_left <= 0;
      end else if (quiet) rsp_tready <= 1;
      else if (idle_left != 0) begin
         rsp_tready <= 0;
         idle_left <= idle_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 0;
         idle_left <= int'($urandom_range(0, 5));
      end else rsp_tready <= 1;
   end

   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_off = 1;
      repeat (60) @(posedge clock);
      hold_off = 0;
   end

   function automatic logic [23:0] rand_coord(int mode);
      case (mode)
         0: return 24'($signed($urandom_range(0, 200)) - 100);
         1: return 24'($urandom);
         2: return 24'h7fffff;
         default: return 24'h800000;
      endcase
   endfunction

   task automatic send(logic cmd, logic [fsc_pkg::REQ_DATA_W-1:0] d);
      if (!quiet) while ($urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= cmd; req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_plane(logic [2:0] idx, logic [17:0] nx, logic [17:0] ny,
                             logic [17:0] nz, logic [39:0] w);
      logic [fsc_pkg::REQ_DATA_W-1:0] d;
      d = fsc_pkg::REQ_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom});
      d[96:0] = {w, nz, ny, nx, idx};
      d[fsc_pkg::REQ_DATA_W-1:241] = '0;
      send(fsc_pkg::CMD_LOAD, d);
   endtask

   task automatic test_box(int mode);
      logic [fsc_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[96:0] = 97'({$urandom, $urandom, $urandom, $urandom});
      for (int i = 0; i < 6; i++) d[97 + i*24 +: 24] = rand_coord(mode);
      send(fsc_pkg::CMD_TEST, d);
   endtask

   task automatic load_frustum(int scale);
      for (int p = 0; p < 6; p++)
         load_plane(3'(p), 18'($urandom_range(0, 262143)), 18'($urandom),
                    18'($urandom), 40'($signed($urandom_range(0, 2*scale)) - scale)
                    <<< 16);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Unloaded planes never cull, even for a point box.
      test_box(0);
      test_box(2);
      for (int i = 0; i < 3; i++) test_box(3);
      // Extreme plane values, two out-of-range indices, and an axis plane.
      load_plane(0, 18'h1ffff, 18'h20000, 18'h0, 40'h7fffffffff);
      load_plane(1, 18'h20000, 18'h1ffff, 18'h3ffff, 40'h8000000000);
      load_plane(6, 18'h10000, 18'h0, 18'h0, 40'hffffff0000);
      load_plane(7, 18'h3ffff, 18'h3ffff, 18'h3ffff, 40'h0);
      load_plane(2, 18'h10000, 18'h0, 18'h0, 40'h0);
      for (int m = 0; m < 4; m++) test_box(m);
      for (int i = 0; i < 8; i++) test_box(1);
      for (int i = 0; i < 1000; i++) begin
         if (i % 100 == 0) load_frustum(($urandom_range(0, 1)) ? 200 : 32'h7fffff);
         if (i == 500) begin
            req_tvalid <= 0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
            repeat (10) @(posedge clock);
         end
         if (i == 850) quiet = 1;
         if ($urandom_range(0, 19) == 0)
            load_plane(3'($urandom_range(0, 7)), 18'($urandom), 18'($urandom),
                       18'($urandom), 40'({$urandom, $urandom}));
         else test_box($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3));
      end
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Tested %0d boxes, %0d culled, across random and extreme frustums.",
               tests_seen, culled_seen);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
